// ----- hdl/eulrot_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eulrot_pkg
// Shared constants for the Euler angle to rigid transform block: CORDIC
// arctangent table, gain start value and default configuration.
// ----------------------------------------------------------------------------
package eulrot_pkg;

   localparam int CORDIC_STEPS   = 16;
   localparam int COEF_FRAC_BITS = 16;
   localparam int ATAN_ENTRIES   = 24;
   localparam int OUT_FRAC       = 16;
   localparam int ANGLE_WIDTH    = 16;
   localparam int POS_WIDTH      = 32;
   localparam int COEF_OUT_WIDTH = 18;
   localparam int Z_WIDTH        = 34;

   localparam longint GAIN_Q30 = 64'sd652032875;

   // atan(2^-i) in units of 2^-32 turn
   localparam longint ATAN_TURN32 [ATAN_ENTRIES] = '{
      64'sd536870912, 64'sd316933405, 64'sd167458907, 64'sd85004756,
      64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
      64'sd2670163,   64'sd1335086,   64'sd667544,    64'sd333772,
      64'sd166886,    64'sd83443,     64'sd41721,     64'sd20860,
      64'sd10430,     64'sd5215,      64'sd2607,      64'sd1303,
      64'sd651,       64'sd325,       64'sd162,       64'sd81
   };

   // converged gain rounded to frac fractional bits
   function automatic longint gain_start(input int frac);
      longint acc;
      acc = GAIN_Q30 + (64'sd1 <<< (29 - frac));
      return acc >>> (30 - frac);
   endfunction

endpackage

// ----- hdl/eulrot_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eulrot_cordic
// Pipelined rotation-mode CORDIC: quadrant fold, one iteration per stage,
// then sign restore and clamp to plus or minus one.
// ----------------------------------------------------------------------------
module eulrot_cordic #(
   parameter int STEPS = eulrot_pkg::CORDIC_STEPS,
   parameter int FRAC  = eulrot_pkg::COEF_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic signed [15:0]     angle,
   output logic signed [FRAC+1:0] sin_out,
   output logic signed [FRAC+1:0] cos_out
);

   localparam int XW = FRAC + 3;
   localparam int ZW = eulrot_pkg::Z_WIDTH;
   localparam logic signed [XW-1:0] X_START = XW'(eulrot_pkg::gain_start(FRAC));
   localparam logic signed [XW-1:0] ONE     = XW'(64'sd1 <<< FRAC);

   logic signed [XW-1:0] x_ff [0:STEPS];
   logic signed [XW-1:0] y_ff [0:STEPS];
   logic signed [ZW-1:0] z_ff [0:STEPS];
   logic                 flip_ff [0:STEPS];

   logic signed [16:0]   p_ext;
   logic signed [16:0]   p_fold;
   logic                 flip_in;
   logic signed [ZW-1:0] z_in;
   logic signed [XW-1:0] x_fin;
   logic signed [XW-1:0] y_fin;
   logic signed [XW-1:0] cos_in;
   logic signed [XW-1:0] sin_in;
   logic signed [FRAC+1:0] cos_ff;
   logic signed [FRAC+1:0] sin_ff;

   // fold into [-quarter, +quarter] turn
   always_comb begin
      p_ext = {angle[15], angle};
      if (p_ext > 17'sd16384) begin
         p_fold  = p_ext - 17'sd32768;
         flip_in = 1'b1;
      end else if (p_ext < -17'sd16384) begin
         p_fold  = p_ext + 17'sd32768;
         flip_in = 1'b1;
      end else begin
         p_fold  = p_ext;
         flip_in = 1'b0;
      end
      z_in = ZW'(p_fold) <<< 16;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= X_START;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_in;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_iter
      localparam logic signed [ZW-1:0] ATAN = ZW'(eulrot_pkg::ATAN_TURN32[i]);
      always_ff @(posedge clock) begin
         if (enable) begin
            if (!z_ff[i][ZW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + ATAN;
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   always_comb begin
      x_fin = flip_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];
      y_fin = flip_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS];
      priority if (x_fin > ONE)  cos_in = ONE;
      else if (x_fin < -ONE)     cos_in = -ONE;
      else                       cos_in = x_fin;
      priority if (y_fin > ONE)  sin_in = ONE;
      else if (y_fin < -ONE)     sin_in = -ONE;
      else                       sin_in = y_fin;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cos_ff <= (FRAC+2)'(cos_in);
         sin_ff <= (FRAC+2)'(sin_in);
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ----- hdl/euler_to_rotation_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Euler angles and position to a 3x4 rigid transform, R = yaw * pitch * roll.
// ----------------------------------------------------------------------------
// Fully pipelined: one word in and one word out per cycle while the result
// side does not stall, with a fold stage, one CORDIC iteration per stage, a
// clamp stage, two product stages and the output register. Three CORDIC
// pipelines run side by side for pitch, yaw and roll. A stall on a valid
// result freezes the whole pipeline and is passed back as req_stall.
// Rotation entries are Q2.16 clamped to plus or minus one; the position
// passes through unchanged.
module euler_to_rotation_matrix #(
   parameter int CORDIC_STEPS   = eulrot_pkg::CORDIC_STEPS,
   parameter int COEF_FRAC_BITS = eulrot_pkg::COEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_yaw_angle,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [17:0] rsp_r00,
   output logic signed [17:0] rsp_r01,
   output logic signed [17:0] rsp_r02,
   output logic signed [17:0] rsp_r10,
   output logic signed [17:0] rsp_r11,
   output logic signed [17:0] rsp_r12,
   output logic signed [17:0] rsp_r20,
   output logic signed [17:0] rsp_r21,
   output logic signed [17:0] rsp_r22,
   output logic signed [31:0] rsp_t0,
   output logic signed [31:0] rsp_t1,
   output logic signed [31:0] rsp_t2
);

   localparam int F     = COEF_FRAC_BITS;
   localparam int STEPS = (CORDIC_STEPS > eulrot_pkg::ATAN_ENTRIES) ?
                          eulrot_pkg::ATAN_ENTRIES : CORDIC_STEPS;
   localparam int CW    = F + 2;
   localparam int SW    = CW + 1;
   localparam int LAT   = STEPS + 5;
   localparam int SHR   = (F > eulrot_pkg::OUT_FRAC) ? F - eulrot_pkg::OUT_FRAC : 0;
   localparam int SHL   = (F < eulrot_pkg::OUT_FRAC) ? eulrot_pkg::OUT_FRAC - F : 0;
   localparam int RW    = SW + SHL + 1;
   localparam logic signed [RW-1:0] RND  = (SHR > 0) ? RW'(64'sd1 <<< (SHR - 1)) : '0;
   localparam logic signed [RW-1:0] QONE = RW'(64'sd1 <<< eulrot_pkg::OUT_FRAC);

   function automatic logic signed [CW-1:0] fmul(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
      logic signed [2*CW-1:0] pr;
      pr = (2*CW)'(a) * (2*CW)'(b) + ((2*CW)'(1) <<< (F - 1));
      return CW'(pr >>> F);
   endfunction

   function automatic logic signed [17:0] to_q16(input logic signed [SW-1:0] v);
      logic signed [RW-1:0] r;
      r = ((RW'(v) + RND) >>> SHR) <<< SHL;
      priority if (r > QONE) r = QONE;
      else if (r < -QONE)    r = -QONE;
      return 18'(r);
   endfunction

   logic advance;
   logic vld_ff [0:LAT-2];
   logic rsp_valid_ff;
   logic signed [31:0] px_ff [0:LAT-2];
   logic signed [31:0] py_ff [0:LAT-2];
   logic signed [31:0] pz_ff [0:LAT-2];

   logic signed [CW-1:0] sp, cp, sy, cy, sr, cr;

   // first product stage
   logic signed [CW-1:0] cpcy_a_ff, cpsy_a_ff, srcp_a_ff, crcp_a_ff;
   logic signed [CW-1:0] crcy_a_ff, crsy_a_ff, srcy_a_ff, srsy_a_ff, sp_a_ff;
   // second product stage
   logic signed [CW-1:0] cpcy_b_ff, cpsy_b_ff, srcp_b_ff, crcp_b_ff;
   logic signed [CW-1:0] crcy_b_ff, crsy_b_ff, srcy_b_ff, srsy_b_ff, sp_b_ff;
   logic signed [CW-1:0] spsrcy_b_ff, spcrcy_b_ff, spsrsy_b_ff, spcrsy_b_ff;

   logic signed [17:0] r00_ff, r01_ff, r02_ff, r10_ff, r11_ff, r12_ff;
   logic signed [17:0] r20_ff, r21_ff, r22_ff;
   logic signed [31:0] t0_ff, t1_ff, t2_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   eulrot_cordic #(.STEPS(STEPS), .FRAC(F)) u_pitch (
      .clock(clock), .enable(advance), .angle(req_pitch_angle),
      .sin_out(sp), .cos_out(cp));
   eulrot_cordic #(.STEPS(STEPS), .FRAC(F)) u_yaw (
      .clock(clock), .enable(advance), .angle(req_yaw_angle),
      .sin_out(sy), .cos_out(cy));
   eulrot_cordic #(.STEPS(STEPS), .FRAC(F)) u_roll (
      .clock(clock), .enable(advance), .angle(req_roll_angle),
      .sin_out(sr), .cos_out(cr));

   // valid bits travel alongside the words
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAT - 2; i++) vld_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i <= LAT - 2; i++) vld_ff[i] <= vld_ff[i-1];
         rsp_valid_ff <= vld_ff[LAT-2];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff[0] <= req_pos_x;
         py_ff[0] <= req_pos_y;
         pz_ff[0] <= req_pos_z;
         for (int i = 1; i <= LAT - 2; i++) begin
            px_ff[i] <= px_ff[i-1];
            py_ff[i] <= py_ff[i-1];
            pz_ff[i] <= pz_ff[i-1];
         end
         t0_ff <= px_ff[LAT-2];
         t1_ff <= py_ff[LAT-2];
         t2_ff <= pz_ff[LAT-2];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cpcy_a_ff <= fmul(cp, cy);
         cpsy_a_ff <= fmul(cp, sy);
         srcp_a_ff <= fmul(sr, cp);
         crcp_a_ff <= fmul(cr, cp);
         crcy_a_ff <= fmul(cr, cy);
         crsy_a_ff <= fmul(cr, sy);
         srcy_a_ff <= fmul(sr, cy);
         srsy_a_ff <= fmul(sr, sy);
         sp_a_ff   <= sp;

         cpcy_b_ff   <= cpcy_a_ff;
         cpsy_b_ff   <= cpsy_a_ff;
         srcp_b_ff   <= srcp_a_ff;
         crcp_b_ff   <= crcp_a_ff;
         crcy_b_ff   <= crcy_a_ff;
         crsy_b_ff   <= crsy_a_ff;
         srcy_b_ff   <= srcy_a_ff;
         srsy_b_ff   <= srsy_a_ff;
         sp_b_ff     <= sp_a_ff;
         spsrcy_b_ff <= fmul(sp_a_ff, srcy_a_ff);
         spcrcy_b_ff <= fmul(sp_a_ff, crcy_a_ff);
         spsrsy_b_ff <= fmul(sp_a_ff, srsy_a_ff);
         spcrsy_b_ff <= fmul(sp_a_ff, crsy_a_ff);

         r00_ff <= to_q16(SW'(cpcy_b_ff));
         r01_ff <= to_q16(SW'(spsrcy_b_ff) - SW'(crsy_b_ff));
         r02_ff <= to_q16(SW'(spcrcy_b_ff) + SW'(srsy_b_ff));
         r10_ff <= to_q16(SW'(cpsy_b_ff));
         r11_ff <= to_q16(SW'(spsrsy_b_ff) + SW'(crcy_b_ff));
         r12_ff <= to_q16(SW'(spcrsy_b_ff) - SW'(srcy_b_ff));
         r20_ff <= to_q16(SW'(0) - SW'(sp_b_ff));
         r21_ff <= to_q16(SW'(srcp_b_ff));
         r22_ff <= to_q16(SW'(crcp_b_ff));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_r00   = r00_ff;
   assign rsp_r01   = r01_ff;
   assign rsp_r02   = r02_ff;
   assign rsp_r10   = r10_ff;
   assign rsp_r11   = r11_ff;
   assign rsp_r12   = r12_ff;
   assign rsp_r20   = r20_ff;
   assign rsp_r21   = r21_ff;
   assign rsp_r22   = r22_ff;
   assign rsp_t0    = t0_ff;
   assign rsp_t1    = t1_ff;
   assign rsp_t2    = t2_ff;

endmodule

// ----- dv/euler_to_rotation_matrix_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_checker
// Watches both channels of the transform block, works out the expected
// matrix and translation for every accepted word and compares in order.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_checker #(
   parameter int CORDIC_STEPS   = eulrot_pkg::CORDIC_STEPS,
   parameter int COEF_FRAC_BITS = eulrot_pkg::COEF_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_yaw_angle,
   input  logic signed [15:0] req_roll_angle,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [17:0] rsp_r00,
   input  logic signed [17:0] rsp_r01,
   input  logic signed [17:0] rsp_r02,
   input  logic signed [17:0] rsp_r10,
   input  logic signed [17:0] rsp_r11,
   input  logic signed [17:0] rsp_r12,
   input  logic signed [17:0] rsp_r20,
   input  logic signed [17:0] rsp_r21,
   input  logic signed [17:0] rsp_r22,
   input  logic signed [31:0] rsp_t0,
   input  logic signed [31:0] rsp_t1,
   input  logic signed [31:0] rsp_t2,
   output int                 pending_transforms,
   output int                 error_count
);

   typedef struct {
      logic signed [17:0] r [9];
      logic signed [31:0] t [3];
   } transform_type;

   transform_type expected_transforms [$];

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic void cordic_sin_cos(input logic signed [15:0] ang,
                                          output longint s, output longint c);
      longint p, x, y, z, nx, one;
      bit flip;
      int steps;
      p = ang;
      flip = 0;
      if (p > 16384) begin
         p -= 32768;
         flip = 1;
      end else if (p < -16384) begin
         p += 32768;
         flip = 1;
      end
      one = 64'sd1 <<< COEF_FRAC_BITS;
      x = shr_floor(eulrot_pkg::GAIN_Q30 + (64'sd1 <<< (29 - COEF_FRAC_BITS)),
                    30 - COEF_FRAC_BITS);
      y = 0;
      z = p * 65536;
      steps = CORDIC_STEPS > eulrot_pkg::ATAN_ENTRIES ? eulrot_pkg::ATAN_ENTRIES
                                                      : CORDIC_STEPS;
      for (int i = 0; i < steps; i++) begin
         if (z >= 0) begin
            nx = x - shr_floor(y, i);
            y = y + shr_floor(x, i);
            z -= eulrot_pkg::ATAN_TURN32[i];
         end else begin
            nx = x + shr_floor(y, i);
            y = y - shr_floor(x, i);
            z += eulrot_pkg::ATAN_TURN32[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = clip(x, one);
      s = clip(y, one);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return shr_floor(a * b + (64'sd1 <<< (COEF_FRAC_BITS - 1)), COEF_FRAC_BITS);
   endfunction

   function automatic logic signed [17:0] to_entry(longint v);
      int sh;
      longint r;
      sh = COEF_FRAC_BITS - 16;
      if (sh > 0) r = shr_floor(v + (64'sd1 <<< (sh - 1)), sh);
      else if (sh < 0) r = v * (64'sd1 <<< (-sh));
      else r = v;
      return 18'(clip(r, 64'sd65536));
   endfunction

   function automatic transform_type rigid_transform(
         logic signed [15:0] pitch, yaw, roll,
         logic signed [31:0] px, py, pz);
      transform_type m;
      longint sp, cp, sy, cy, sr, cr, crcy, crsy, srcy, srsy;
      cordic_sin_cos(pitch, sp, cp);
      cordic_sin_cos(yaw, sy, cy);
      cordic_sin_cos(roll, sr, cr);
      crcy = qmul(cr, cy);
      crsy = qmul(cr, sy);
      srcy = qmul(sr, cy);
      srsy = qmul(sr, sy);
      m.r[0] = to_entry(qmul(cp, cy));
      m.r[1] = to_entry(qmul(sp, srcy) - crsy);
      m.r[2] = to_entry(qmul(sp, crcy) + srsy);
      m.r[3] = to_entry(qmul(cp, sy));
      m.r[4] = to_entry(qmul(sp, srsy) + crcy);
      m.r[5] = to_entry(qmul(sp, crsy) - srcy);
      m.r[6] = to_entry(-sp);
      m.r[7] = to_entry(qmul(sr, cp));
      m.r[8] = to_entry(qmul(cr, cp));
      m.t[0] = px;
      m.t[1] = py;
      m.t[2] = pz;
      return m;
   endfunction

   string entry_names [9] = '{"r00", "r01", "r02", "r10", "r11", "r12",
                              "r20", "r21", "r22"};
   string trans_names [3] = '{"t0", "t1", "t2"};

   assign pending_transforms = expected_transforms.size();

   initial error_count = 0;

   always @(posedge clock) begin
      transform_type want;
      logic signed [17:0] got_r [9];
      logic signed [31:0] got_t [3];
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_transforms.push_back(rigid_transform(req_pitch_angle,
               req_yaw_angle, req_roll_angle, req_pos_x, req_pos_y, req_pos_z));
         if (rsp_valid && !rsp_stall) begin
            got_r = '{rsp_r00, rsp_r01, rsp_r02, rsp_r10, rsp_r11, rsp_r12,
                      rsp_r20, rsp_r21, rsp_r22};
            got_t = '{rsp_t0, rsp_t1, rsp_t2};
            if (expected_transforms.size() == 0) begin
               $error("result word with nothing expected");
               error_count++;
            end else begin
               want = expected_transforms.pop_front();
               for (int i = 0; i < 9; i++)
                  if (got_r[i] !== want.r[i]) begin
                     $error("%s: expected %0d, got %0d", entry_names[i],
                            want.r[i], got_r[i]);
                     error_count++;
                  end
               for (int i = 0; i < 3; i++)
                  if (got_t[i] !== want.t[i]) begin
                     $error("%s: expected %0d, got %0d", trans_names[i],
                            want.t[i], got_t[i]);
                     error_count++;
                  end
            end
         end
      end
   end

endmodule

// ----- dv/euler_to_rotation_matrix_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_test
// Drives directed and random Euler angle words with random gaps and result
// stalls, including a long stall to back up the pipeline, and reports.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_test;

   localparam int LATENCY     = 24 + 5;
   localparam int RANDOM_WORDS = 976;
   localparam longint CYCLE_LIMIT = 200000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_pitch_angle, req_yaw_angle, req_roll_angle;
   logic signed [31:0] req_pos_x, req_pos_y, req_pos_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [17:0] rsp_r00, rsp_r01, rsp_r02, rsp_r10, rsp_r11, rsp_r12;
   logic signed [17:0] rsp_r20, rsp_r21, rsp_r22;
   logic signed [31:0] rsp_t0, rsp_t1, rsp_t2;
   int                 pending_transforms;
   int                 error_count;
   longint             cycle_count;
   bit                 long_hold_request;

   euler_to_rotation_matrix uut (.*);
   euler_to_rotation_matrix_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** euler_to_rotation_matrix: FAILED **");
         $finish;
      end
   end

   // result side: random stalls per word, plus one long hold-off on request
   initial begin
      int wait_cycles;
      rsp_stall = 1'b1;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold_request) begin
            rsp_stall <= 1'b1;
            repeat (200) @(posedge clock);
            long_hold_request = 0;
         end
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock iff rsp_valid);
      end
   end

   task automatic send_word(logic signed [15:0] pitch, yaw, roll,
                            logic signed [31:0] px, py, pz, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pitch_angle <= pitch;
      req_yaw_angle   <= yaw;
      req_roll_angle  <= roll;
      req_pos_x       <= px;
      req_pos_y       <= py;
      req_pos_z       <= pz;
      @(posedge clock iff !req_stall);
   endtask

   function automatic logic signed [15:0] pick_angle();
      unique case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 8) * 8192 + $urandom_range(0, 4) - 2);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int pick_gap(bit burst);
      if (burst) return 0;
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
   endfunction

   initial begin
      logic signed [15:0] corner_angles [10] = '{16'sh0000, 16'sh4000,
         16'shc000, 16'sh4001, 16'shbfff, 16'sh7fff, 16'sh8000, 16'sh2000,
         16'shffff, 16'sh0001};
      bit burst;
      reset = 1'b1;
      long_hold_request = 0;
      req_valid = 1'b0;
      req_pitch_angle = '0;
      req_yaw_angle = '0;
      req_roll_angle = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners: quarter turns, fold boundaries, wrap, zero position
      foreach (corner_angles[i])
         send_word(corner_angles[i], corner_angles[(i + 3) % 10],
                   corner_angles[(i + 7) % 10], 32'sh7fffffff,
                   32'sh80000000, 32'sh0, 0);
      send_word(16'sh4000, 16'sh4000, 16'sh4000, 0, 0, 0, 1);
      send_word(16'shc000, 16'sh8000, 16'sh4000, -1, 1, 32'sh00010000, 2);
      send_word(16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0);
      send_word(16'sh2000, 16'shc000, 16'sh6000, 32'sh80000000,
                32'sh7fffffff, -1, 0);

      // pipeline fill while the result side holds off
      long_hold_request = 1;
      repeat (60)
         send_word(pick_angle(), pick_angle(), pick_angle(), 32'($urandom),
                   32'($urandom), 32'($urandom), 0);

      // pause until drained
      req_valid <= 1'b0;
      @(posedge clock iff pending_transforms == 0);

      burst = 0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 100 == 0) burst = $urandom_range(0, 2) == 0;
         send_word(pick_angle(), pick_angle(), pick_angle(),
                   $urandom_range(0, 9) == 0 ? 32'sh0 : 32'($urandom),
                   32'($urandom), 32'($urandom), pick_gap(burst));
      end
      req_valid <= 1'b0;

      @(posedge clock iff pending_transforms == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0)
         $display("** euler_to_rotation_matrix: PASSED **");
      else
         $display("** euler_to_rotation_matrix: FAILED **");
      $finish;
   end

endmodule
